// ----- rtl/slmx_pkg.sv -----
// Shared types, constants and helpers of the scrolling LED matrix scanner.
// Used by slmx_front, slmx_fifo, slmx_back and the top level; depends on nothing else.
`default_nettype none
package slmx_pkg;

  localparam int BUFFER_WIDTH   = 384;
  localparam int BUFFER_LINES   = 64;
  localparam int PANEL_ROWS     = 16;
  localparam int WORDS_PER_LINE = 12;
  localparam int PLANE_DEPTH    = BUFFER_LINES * WORDS_PER_LINE;
  localparam int ADDR_W         = 10;
  localparam int COL_W          = 9;
  localparam int LINE_W         = 6;
  localparam int WORD_IDX_W     = 4;
  localparam int ROW_W          = 4;
  localparam int PHASE_W        = 4;
  localparam int MOD_W          = 11;
  localparam int QUEUE_DEPTH    = 4;
  localparam int QPTR_W         = 2;

  typedef enum logic [1:0] {
    CMD_WRITE  = 2'd0,
    CMD_SCAN   = 2'd1,
    CMD_SCROLL = 2'd2,
    CMD_HOME   = 2'd3
  } cmd_t;

  typedef enum logic [1:0] {
    CFG_SCROLL_X     = 2'd0,
    CFG_SCROLL_Y     = 2'd1,
    CFG_SCROLL_WIDTH = 2'd2
  } cfg_index_t;

  typedef enum logic [2:0] {
    OP_NOP    = 3'd0,
    OP_WRITE  = 3'd1,
    OP_SCAN   = 3'd2,
    OP_SCROLL = 3'd3,
    OP_HOME   = 3'd4
  } op_kind_t;

  typedef struct packed {
    op_kind_t          kind;
    logic              plane;
    logic [ADDR_W-1:0] addr;
    logic [31:0]       data;
  } op_t;

  function automatic logic [ADDR_W-1:0] word_addr(input logic [LINE_W-1:0] ln,
                                                  input logic [WORD_IDX_W-1:0] w);
    logic [ADDR_W-1:0] l;
    l = ADDR_W'(ln);
    return (l << 3) + (l << 2) + ADDR_W'(w);
  endfunction

  function automatic logic [31:0] plane_pick(input logic [PHASE_W-1:0] ph,
                                             input logic [31:0] p0,
                                             input logic [31:0] p1);
    logic [31:0] r;
    case (ph)
      4'd0, 4'd3, 4'd6, 4'd9: r = p0;
      4'd1, 4'd5:             r = p1;
      default:                r = p0 & p1;
    endcase
    return r;
  endfunction

endpackage
`default_nettype wire

// ----- rtl/slmx_ram.sv -----
// Generic single-port-write, single-port-read RAM with registered read data.
// Standalone; sized by its WIDTH and DEPTH parameters.
`default_nettype none
module slmx_ram #(
  parameter int WIDTH = 32,
  parameter int DEPTH = 768
) (
  input  wire logic                     clk,
  input  wire logic                     we,
  input  wire logic [$clog2(DEPTH)-1:0] waddr,
  input  wire logic [WIDTH-1:0]         wdata,
  input  wire logic [$clog2(DEPTH)-1:0] raddr,
  output logic      [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule
`default_nettype wire

// ----- rtl/slmx_front.sv -----
// Input stage: accepts stream transfers, decodes the command and range-checks writes.
// Depends on slmx_pkg.
`default_nettype none
module slmx_front (
  input  wire logic           clk,
  input  wire logic           rst,
  input  wire logic           hold,
  input  wire logic           in_valid,
  output logic                in_ready,
  input  wire logic [1:0]     in_cmd,
  input  wire logic [47:0]    in_data,
  output logic                out_valid,
  input  wire logic           out_ready,
  output slmx_pkg::op_t       out_op
);

  slmx_pkg::op_t op_next;
  logic [slmx_pkg::LINE_W-1:0]     f_line;
  logic [slmx_pkg::WORD_IDX_W-1:0] f_word;

  assign f_line   = in_data[6:1];
  assign f_word   = in_data[10:7];
  assign in_ready = (!out_valid || out_ready) && !hold;

  always_comb begin
    op_next.plane = in_data[0];
    op_next.addr  = slmx_pkg::word_addr(f_line, f_word);
    op_next.data  = in_data[42:11];
    unique case (slmx_pkg::cmd_t'(in_cmd))
      slmx_pkg::CMD_WRITE: begin
        op_next.kind = (f_word < slmx_pkg::WORD_IDX_W'(slmx_pkg::WORDS_PER_LINE))
                       ? slmx_pkg::OP_WRITE : slmx_pkg::OP_NOP;
      end
      slmx_pkg::CMD_SCAN:   op_next.kind = slmx_pkg::OP_SCAN;
      slmx_pkg::CMD_SCROLL: op_next.kind = slmx_pkg::OP_SCROLL;
      slmx_pkg::CMD_HOME:   op_next.kind = slmx_pkg::OP_HOME;
      default:              op_next.kind = slmx_pkg::OP_NOP;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (in_valid && in_ready) begin
      out_valid <= 1'b1;
    end else if (out_ready) begin
      out_valid <= 1'b0;
    end
    if (in_valid && in_ready) begin
      out_op <= op_next;
    end
  end

endmodule
`default_nettype wire

// ----- rtl/slmx_fifo.sv -----
// Short command queue between the input stage and the execution stage.
// Depends on slmx_pkg.
`default_nettype none
module slmx_fifo (
  input  wire logic     clk,
  input  wire logic     rst,
  input  wire logic     in_valid,
  output logic          in_ready,
  input  slmx_pkg::op_t in_op,
  output logic          out_valid,
  input  wire logic     out_ready,
  output slmx_pkg::op_t out_op
);

  slmx_pkg::op_t                 slots [slmx_pkg::QUEUE_DEPTH];
  logic [slmx_pkg::QPTR_W-1:0]   wptr;
  logic [slmx_pkg::QPTR_W-1:0]   rptr;
  logic [slmx_pkg::QPTR_W:0]     count;
  logic                          push;
  logic                          pop;

  assign in_ready  = count != (slmx_pkg::QPTR_W + 1)'(slmx_pkg::QUEUE_DEPTH);
  assign out_valid = count != '0;
  assign out_op    = slots[rptr];
  assign push      = in_valid && in_ready;
  assign pop       = out_valid && out_ready;

  always_ff @(posedge clk) begin
    if (rst) begin
      wptr  <= '0;
      rptr  <= '0;
      count <= '0;
    end else begin
      if (push) begin
        wptr <= wptr + 1'b1;
      end
      if (pop) begin
        rptr <= rptr + 1'b1;
      end
      if (push && !pop) begin
        count <= count + 1'b1;
      end else if (pop && !push) begin
        count <= count - 1'b1;
      end
    end
    if (push) begin
      slots[wptr] <= in_op;
    end
  end

endmodule
`default_nettype wire

// ----- rtl/slmx_back.sv -----
// Execution stage: frame buffer, viewport state, row gather and shift-beat output.
// Depends on slmx_pkg and slmx_ram.
`default_nettype none
module slmx_back (
  input  wire logic        clk,
  input  wire logic        rst,
  input  wire logic        cfg_we,
  input  wire logic [1:0]  cfg_index,
  input  wire logic [8:0]  cfg_data,
  input  wire logic        op_valid,
  output logic             op_ready,
  input  slmx_pkg::op_t    op,
  output logic             clearing,
  output logic             m_tvalid,
  input  wire logic        m_tready,
  output logic [7:0]       m_tdata,
  output logic             m_tlast
);

  typedef enum logic [2:0] {
    ST_CLEAR, ST_RUN, ST_MOD, ST_RDB, ST_RDZ, ST_LOADW, ST_WALK, ST_HOLD
  } state_t;

  localparam int AW = slmx_pkg::ADDR_W;
  localparam int CW = slmx_pkg::COL_W;
  localparam int MW = slmx_pkg::MOD_W;

  state_t                          state;
  logic [AW-1:0]                   clr_addr;
  logic [1:0]                      scroll_x;
  logic [1:0]                      scroll_y;
  logic [CW-1:0]                   scroll_width;
  logic [CW-1:0]                   view_left;
  logic [slmx_pkg::LINE_W-1:0]     view_top;
  logic [slmx_pkg::ROW_W-1:0]      scan_row;
  logic [slmx_pkg::PHASE_W-1:0]    frame_phase;
  logic [MW-1:0]                   mod_r;
  logic [3:0]                      mod_k;
  logic [slmx_pkg::LINE_W-1:0]     s_line;
  logic [slmx_pkg::WORD_IDX_W-1:0] s_word;
  logic [slmx_pkg::PHASE_W-1:0]    s_phase;
  logic [CW-1:0]                   s_vl;
  logic [CW-1:0]                   s_w;
  logic [slmx_pkg::ROW_W-1:0]      s_target;
  logic [31:0]                     wa;
  logic [31:0]                     wb;
  logic [31:0]                     wz;
  logic [CW-1:0]                   walk_x;
  logic                            walk_wrap;
  logic [2:0]                      walk_cnt;
  logic [31:0]                     row_acc;
  logic [3:0]                      em_cnt;
  logic [15:0]                     em_hi;
  logic [15:0]                     em_lo;
  logic [slmx_pkg::ROW_W-1:0]      em_target;

  logic [CW-1:0]                   eff_w;
  logic [slmx_pkg::LINE_W-1:0]     ln_now;
  logic [slmx_pkg::WORD_IDX_W-1:0] next_word;
  logic                            we0;
  logic                            we1;
  logic [AW-1:0]                   waddr;
  logic [31:0]                     wdata;
  logic [AW-1:0]                   raddr;
  logic [31:0]                     rdata0;
  logic [31:0]                     rdata1;
  logic [31:0]                     rword;
  logic                            take;
  logic                            emit_free;
  logic                            emit_load;
  logic [20:0]                     mod_wsh;
  logic                            mod_ge;
  logic [MW-1:0]                   mod_sub;
  logic [MW-1:0]                   mod_init;
  logic [CW-1:0]                   walk_x_next;
  logic                            walk_wrap_next;
  logic [3:0]                      walk_bits;
  logic [63:0]                     ab;

  assign clearing  = state == ST_CLEAR;
  assign op_ready  = state == ST_RUN;
  assign take      = op_valid && op_ready;
  assign emit_free = !m_tvalid || (m_tready && em_cnt == 4'd15);
  assign emit_load = state == ST_HOLD && emit_free;

  assign m_tdata = {5'b0, em_hi[15], em_lo[15], em_cnt == em_target};
  assign m_tlast = em_cnt == 4'd15;

  always_comb begin
    if (scroll_width == '0) begin
      eff_w = CW'(1);
    end else if (scroll_width > CW'(slmx_pkg::BUFFER_WIDTH)) begin
      eff_w = CW'(slmx_pkg::BUFFER_WIDTH);
    end else begin
      eff_w = scroll_width;
    end
  end

  assign ln_now    = view_top + slmx_pkg::LINE_W'(scan_row);
  assign next_word = (s_word == slmx_pkg::WORD_IDX_W'(slmx_pkg::WORDS_PER_LINE - 1))
                     ? '0 : s_word + 1'b1;

  always_comb begin
    we0   = 1'b0;
    we1   = 1'b0;
    waddr = op.addr;
    wdata = op.data;
    if (state == ST_CLEAR) begin
      we0   = 1'b1;
      we1   = 1'b1;
      waddr = clr_addr;
      wdata = '0;
    end else if (take && op.kind == slmx_pkg::OP_WRITE) begin
      we0 = !op.plane;
      we1 = op.plane;
    end
  end

  always_comb begin
    case (state)
      ST_RDB:  raddr = slmx_pkg::word_addr(s_line, next_word);
      ST_RDZ:  raddr = slmx_pkg::word_addr(s_line, '0);
      default: raddr = slmx_pkg::word_addr(ln_now, view_left[8:5]);
    endcase
  end

  slmx_ram #(.WIDTH(32), .DEPTH(slmx_pkg::PLANE_DEPTH)) u_plane0 (
    .clk   (clk),
    .we    (we0),
    .waddr (waddr),
    .wdata (wdata),
    .raddr (raddr),
    .rdata (rdata0)
  );

  slmx_ram #(.WIDTH(32), .DEPTH(slmx_pkg::PLANE_DEPTH)) u_plane1 (
    .clk   (clk),
    .we    (we1),
    .waddr (waddr),
    .wdata (wdata),
    .raddr (raddr),
    .rdata (rdata1)
  );

  assign rword = slmx_pkg::plane_pick(s_phase, rdata0, rdata1);

  assign mod_init = MW'(view_left) + (MW'(eff_w) << 1) + {{(MW-2){scroll_x[1]}}, scroll_x};
  assign mod_wsh  = 21'(s_w) << mod_k;
  assign mod_ge   = (mod_r >> mod_k) >= MW'(s_w);
  assign mod_sub  = mod_r - mod_wsh[MW-1:0];

  assign ab = {wa, wb};

  always_comb begin
    logic [CW-1:0] x;
    logic          wr;
    logic [5:0]    k;
    logic [CW:0]   xn;
    x  = walk_x;
    wr = walk_wrap;
    for (int j = 0; j < 4; j++) begin
      k = 6'(x - {s_vl[8:5], 5'b0});
      walk_bits[3-j] = wr ? wz[~x[4:0]] : ab[~k];
      xn = {1'b0, x} + 1'b1;
      if (xn >= {1'b0, s_w}) begin
        x  = '0;
        wr = 1'b1;
      end else begin
        x = xn[CW-1:0];
      end
    end
    walk_x_next    = x;
    walk_wrap_next = wr;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state        <= ST_CLEAR;
      clr_addr     <= '0;
      scroll_x     <= 2'b01;
      scroll_y     <= 2'b00;
      scroll_width <= CW'(slmx_pkg::BUFFER_WIDTH);
      view_left    <= '0;
      view_top     <= '0;
      scan_row     <= '0;
      frame_phase  <= '0;
      m_tvalid     <= 1'b0;
      em_cnt       <= '0;
    end else begin
      if (cfg_we) begin
        case (slmx_pkg::cfg_index_t'(cfg_index))
          slmx_pkg::CFG_SCROLL_X:     scroll_x     <= cfg_data[1:0];
          slmx_pkg::CFG_SCROLL_Y:     scroll_y     <= cfg_data[1:0];
          slmx_pkg::CFG_SCROLL_WIDTH: scroll_width <= cfg_data;
          default: ;
        endcase
      end

      if (m_tvalid && m_tready && !emit_load) begin
        if (em_cnt == 4'd15) begin
          m_tvalid <= 1'b0;
        end
        em_cnt <= em_cnt + 1'b1;
        em_hi  <= {em_hi[14:0], 1'b0};
        em_lo  <= {em_lo[14:0], 1'b0};
      end

      unique case (state)
        ST_CLEAR: begin
          clr_addr <= clr_addr + 1'b1;
          if (clr_addr == AW'(slmx_pkg::PLANE_DEPTH - 1)) begin
            state <= ST_RUN;
          end
        end
        ST_RUN: begin
          if (take) begin
            case (op.kind)
              slmx_pkg::OP_SCAN: begin
                s_line   <= ln_now;
                s_word   <= view_left[8:5];
                s_phase  <= frame_phase;
                s_vl     <= view_left;
                s_w      <= eff_w;
                s_target <= slmx_pkg::ROW_W'(slmx_pkg::PANEL_ROWS - 1) - scan_row;
                scan_row <= scan_row + 1'b1;
                if (scan_row == slmx_pkg::ROW_W'(slmx_pkg::PANEL_ROWS - 1)) begin
                  frame_phase <= frame_phase + 1'b1;
                end
                state <= ST_RDB;
              end
              slmx_pkg::OP_SCROLL: begin
                mod_r    <= mod_init;
                mod_k    <= 4'(MW - 1);
                s_w      <= eff_w;
                view_top <= view_top + {{(slmx_pkg::LINE_W-2){scroll_y[1]}}, scroll_y};
                state    <= ST_MOD;
              end
              slmx_pkg::OP_HOME: begin
                view_left <= '0;
                view_top  <= '0;
              end
              default: ;
            endcase
          end
        end
        ST_MOD: begin
          if (mod_ge) begin
            mod_r <= mod_sub;
          end
          if (mod_k == '0) begin
            view_left <= mod_ge ? mod_sub[CW-1:0] : mod_r[CW-1:0];
            state     <= ST_RUN;
          end else begin
            mod_k <= mod_k - 1'b1;
          end
        end
        ST_RDB: begin
          wa    <= rword;
          state <= ST_RDZ;
        end
        ST_RDZ: begin
          wb    <= rword;
          state <= ST_LOADW;
        end
        ST_LOADW: begin
          wz        <= rword;
          walk_x    <= s_vl;
          walk_wrap <= 1'b0;
          walk_cnt  <= '0;
          state     <= ST_WALK;
        end
        ST_WALK: begin
          walk_x    <= walk_x_next;
          walk_wrap <= walk_wrap_next;
          walk_cnt  <= walk_cnt + 1'b1;
          row_acc   <= {row_acc[27:0], walk_bits};
          if (walk_cnt == 3'd7) begin
            state <= ST_HOLD;
          end
        end
        ST_HOLD: begin
          if (emit_free) begin
            m_tvalid  <= 1'b1;
            em_cnt    <= '0;
            em_hi     <= row_acc[31:16];
            em_lo     <= row_acc[15:0];
            em_target <= s_target;
            state     <= ST_RUN;
          end
        end
        default: state <= ST_RUN;
      endcase
    end
  end

endmodule
`default_nettype wire

// ----- rtl/scrolling_led_matrix_scanner_top.sv -----
// Top level of the scrolling LED matrix scanner.
// Depends on slmx_pkg, slmx_front, slmx_fifo and slmx_back.
//
// Input stream (s_*): one command per transfer, kind in s_tuser. Writes store
// one 32-pixel word into plane 0 or 1 of the 64-line frame buffer; scroll and
// home ticks move the viewport; a scan tick gathers 32 pixels of the current
// panel row and produces 16 output transfers.
// Output stream (m_*): one shift beat per transfer with the row select bit and
// the two column bits; m_tlast marks the beat after which the row is latched.
// Configuration: cfg_we writes cfg_data into register cfg_index (0 step x,
// 1 step y, 2 scroll width) in the same clock; the user must use it only while
// idle, and the block itself does not enforce this. A scan tick passes the input
// register and the queue; the execution stage then reads the row words (RDB, RDZ,
// LOADW), gathers the pixels (WALK) and loads the beats (HOLD). The next row is
// gathered while the current one is shifted out. Writes and home ticks complete
// as they are taken; scroll ticks also pass the shift-and-subtract wrap unit.
// After reset both planes are swept to zero, all 768 words of each, during which
// s_tready stays low. When m_tready is low the beat holds, the queue fills,
// and s_tready then drops.
`default_nettype none
module scrolling_led_matrix_scanner_top (
  input  wire logic        clk,
  input  wire logic        rst,
  input  wire logic        s_tvalid,
  output logic             s_tready,
  input  wire logic [47:0] s_tdata,  // plane_sel, line[5:0], word_index[3:0], word_data[31:0]
  input  wire logic [1:0]  s_tuser,  // cmd[1:0]
  output logic             m_tvalid,
  input  wire logic        m_tready,
  output logic [7:0]       m_tdata,  // row_bit, col_a_bit, col_b_bit
  output logic             m_tlast,
  input  wire logic        cfg_we,
  input  wire logic [1:0]  cfg_index,
  input  wire logic [8:0]  cfg_data
);

  slmx_pkg::op_t front_op;
  slmx_pkg::op_t queue_op;
  logic          front_valid;
  logic          front_ready;
  logic          queue_valid;
  logic          queue_ready;
  logic          clearing;

  slmx_front u_front (
    .clk       (clk),
    .rst       (rst),
    .hold      (clearing),
    .in_valid  (s_tvalid),
    .in_ready  (s_tready),
    .in_cmd    (s_tuser),
    .in_data   (s_tdata),
    .out_valid (front_valid),
    .out_ready (front_ready),
    .out_op    (front_op)
  );

  slmx_fifo u_fifo (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (front_valid),
    .in_ready  (front_ready),
    .in_op     (front_op),
    .out_valid (queue_valid),
    .out_ready (queue_ready),
    .out_op    (queue_op)
  );

  slmx_back u_back (
    .clk       (clk),
    .rst       (rst),
    .cfg_we    (cfg_we),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data),
    .op_valid  (queue_valid),
    .op_ready  (queue_ready),
    .op        (queue_op),
    .clearing  (clearing),
    .m_tvalid  (m_tvalid),
    .m_tready  (m_tready),
    .m_tdata   (m_tdata),
    .m_tlast   (m_tlast)
  );

endmodule
`default_nettype wire

// ----- bench/scrolling_led_matrix_scanner_top_tb.sv -----
// Self-checking testbench for scrolling_led_matrix_scanner_top.
// It predicts every shift beat from its own frame buffer and viewport model and
// checks the output stream. It needs slmx_pkg and the RTL under rtl.
`default_nettype none
module scrolling_led_matrix_scanner_top_tb;
  timeunit 1ns;
  timeprecision 1ps;
  import slmx_pkg::*;

  localparam int SETTLE_CYCLES = 100;
  localparam int STALL_LIMIT   = 3000;
  localparam int RANDOM_ITEMS  = 39;

  typedef struct {
    logic row_bit;
    logic col_a_bit;
    logic col_b_bit;
    logic last;
  } beat_t;

  logic        clk = 1'b0;
  logic        rst = 1'b1;
  logic        s_tvalid = 1'b0;
  logic        s_tready;
  logic [47:0] s_tdata = '0;  // plane_sel, line[5:0], word_index[3:0], word_data[31:0]
  logic [1:0]  s_tuser = '0;  // cmd[1:0]
  logic        m_tvalid;
  logic        m_tready = 1'b0;
  logic [7:0]  m_tdata;       // row_bit, col_a_bit, col_b_bit
  logic        m_tlast;
  logic        cfg_we = 1'b0;
  logic [1:0]  cfg_index = '0;
  logic [8:0]  cfg_data = '0;

  logic [31:0] pix_mem [0:1][0:BUFFER_LINES-1][0:WORDS_PER_LINE-1];
  logic [ROW_W-1:0]   scan_row;
  logic [PHASE_W-1:0] frame_phase;
  logic [COL_W-1:0]   view_left;
  logic [LINE_W-1:0]  view_top;
  logic [1:0]         step_x;
  logic [1:0]         step_y;
  logic [8:0]         wrap_width;

  beat_t expected_beats[$];
  beat_t got;
  int send_idle_pct = 21;
  int recv_idle_pct = 63;
  int errors = 0;
  int commands = 0;
  int scans = 0;
  int beats = 0;
  int reg_writes = 0;
  int stall_count = 0;

  scrolling_led_matrix_scanner_top uut (
    .clk       (clk),
    .rst       (rst),
    .s_tvalid  (s_tvalid),
    .s_tready  (s_tready),
    .s_tdata   (s_tdata),
    .s_tuser   (s_tuser),
    .m_tvalid  (m_tvalid),
    .m_tready  (m_tready),
    .m_tdata   (m_tdata),
    .m_tlast   (m_tlast),
    .cfg_we    (cfg_we),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data)
  );

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  function automatic int scroll_span();
    int w;
    w = int'(wrap_width);
    if (w < 1) w = 1;
    if (w > BUFFER_WIDTH) w = BUFFER_WIDTH;
    return w;
  endfunction

  function automatic logic [31:0] gather_row_pixels();
    int w, ln, p, b, x, i;
    logic [31:0] src, acc;
    w = scroll_span();
    ln = (int'(scan_row) + int'(view_top)) % BUFFER_LINES;
    p = (int'(view_left) / 32) % WORDS_PER_LINE;
    b = int'(view_left) % 32;
    x = int'(view_left);
    acc = '0;
    for (i = 0; i < 32; i++) begin
      case (frame_phase)
        4'd0, 4'd3, 4'd6, 4'd9: src = pix_mem[0][ln][p];
        4'd1, 4'd5:             src = pix_mem[1][ln][p];
        default:                src = pix_mem[0][ln][p] & pix_mem[1][ln][p];
      endcase
      if (src[31-b]) acc[31-i] = 1'b1;
      b++;
      if (b == 32) begin
        b = 0;
        p = (p + 1) % WORDS_PER_LINE;
      end
      x++;
      if (x >= w) begin
        p = 0;
        b = 0;
        x = 0;
      end
    end
    return acc;
  endfunction

  task automatic predict_command(input cmd_t c, input logic pl, input logic [5:0] ln,
                                 input logic [3:0] wi, input logic [31:0] d);
    logic [31:0] row_pixels;
    beat_t e;
    int w, c_idx;
    case (c)
      CMD_WRITE: begin
        if (wi < WORDS_PER_LINE) pix_mem[pl][ln][wi] = d;
      end
      CMD_SCROLL: begin
        w = scroll_span();
        view_left = COL_W'((int'(view_left) + 2 * w + int'($signed(step_x))) % w);
        view_top = LINE_W'((int'(view_top) + 2 * BUFFER_LINES + int'($signed(step_y)))
                           % BUFFER_LINES);
      end
      CMD_HOME: begin
        view_left = '0;
        view_top = '0;
      end
      default: begin
        row_pixels = gather_row_pixels();
        for (c_idx = 0; c_idx < 16; c_idx++) begin
          e.row_bit = (PANEL_ROWS - 1 - int'(scan_row)) == c_idx;
          e.col_a_bit = row_pixels[15-c_idx];
          e.col_b_bit = row_pixels[31-c_idx];
          e.last = c_idx == 15;
          expected_beats.push_back(e);
        end
        if (scan_row == ROW_W'(PANEL_ROWS - 1)) frame_phase = frame_phase + 1'b1;
        scan_row = scan_row + 1'b1;
        scans++;
      end
    endcase
  endtask

  task automatic send_command(input cmd_t c, input logic pl = 1'b0, input logic [5:0] ln = '0,
                              input logic [3:0] wi = '0, input logic [31:0] d = '0);
    while ($urandom_range(0, 99) < send_idle_pct) begin
      s_tvalid <= 1'b0;
      @(posedge clk);
    end
    s_tvalid <= 1'b1;
    s_tuser <= c;
    s_tdata <= {5'b0, d, wi, ln, pl};
    @(posedge clk);
    while (!s_tready) @(posedge clk);
    predict_command(c, pl, ln, wi, d);
    commands++;
  endtask

  task automatic write_reg(input cfg_index_t idx, input logic [8:0] v);
    cfg_we <= 1'b1;
    cfg_index <= idx;
    cfg_data <= v;
    @(posedge clk);
    cfg_we <= 1'b0;
    case (idx)
      CFG_SCROLL_X: step_x = v[1:0];
      CFG_SCROLL_Y: step_y = v[1:0];
      default:      wrap_width = v;
    endcase
    reg_writes++;
    @(posedge clk);
  endtask

  task automatic wait_for_quiet();
    s_tvalid <= 1'b0;
    while (expected_beats.size() != 0) @(posedge clk);
    repeat (SETTLE_CYCLES) @(posedge clk);
  endtask

  task automatic test_buffer_extremes();
    send_command(CMD_WRITE, 1'b0, 6'd0, 4'd0, 32'hFFFF_FFFF);
    send_command(CMD_WRITE, 1'b1, 6'd0, 4'd0, 32'h0000_FFFF);
    send_command(CMD_WRITE, 1'b0, 6'd63, 4'd11, 32'h8000_0001);
    send_command(CMD_WRITE, 1'b1, 6'd63, 4'd11, 32'hFFFF_FFFF);
    send_command(CMD_WRITE, 1'b0, 6'd0, 4'd15, 32'h0000_0000);
    send_command(CMD_WRITE, 1'b1, 6'd0, 4'd12, 32'hFFFF_FFFF);
    send_command(CMD_SCAN);
    send_command(CMD_SCAN);
  endtask

  task automatic test_scroll_and_home();
    wait_for_quiet();
    write_reg(CFG_SCROLL_X, 9'd2);
    write_reg(CFG_SCROLL_Y, 9'd3);
    send_command(CMD_WRITE, 1'b0, 6'd1, 4'd11, 32'h0000_0003);
    send_command(CMD_WRITE, 1'b0, 6'd1, 4'd0, 32'hC3A5_5A3C);
    send_command(CMD_SCROLL);
    send_command(CMD_SCAN);
    send_command(CMD_HOME);
    send_command(CMD_SCAN);
  endtask

  task automatic test_width_limits();
    send_command(CMD_SCROLL);
    wait_for_quiet();
    write_reg(CFG_SCROLL_WIDTH, 9'd40);
    send_command(CMD_SCAN);
    send_command(CMD_SCROLL);
    send_command(CMD_SCAN);
    wait_for_quiet();
    write_reg(CFG_SCROLL_WIDTH, 9'd0);
    write_reg(CFG_SCROLL_X, 9'd1);
    write_reg(CFG_SCROLL_Y, 9'd1);
    send_command(CMD_SCROLL);
    send_command(CMD_SCAN);
    wait_for_quiet();
    write_reg(CFG_SCROLL_WIDTH, 9'd511);
    write_reg(CFG_SCROLL_X, 9'd0);
    write_reg(CFG_SCROLL_Y, 9'd0);
    send_command(CMD_SCROLL);
    send_command(CMD_SCAN);
  endtask

  task automatic test_random_traffic();
    int ph, n, r;
    logic [3:0] wi;
    for (ph = 0; ph < 6; ph++) begin
      wait_for_quiet();
      send_idle_pct = (ph < 2) ? 21 : (ph < 4) ? 63 : 0;
      recv_idle_pct = (ph < 2) ? 63 : (ph < 4) ? 21 : 0;
      case (ph)
        0: begin
          write_reg(CFG_SCROLL_X, 9'd1);
          write_reg(CFG_SCROLL_Y, 9'd1);
          write_reg(CFG_SCROLL_WIDTH, 9'd384);
        end
        1: begin
          write_reg(CFG_SCROLL_X, 9'd2);
          write_reg(CFG_SCROLL_Y, 9'd3);
          write_reg(CFG_SCROLL_WIDTH, 9'd33);
        end
        2: begin
          write_reg(CFG_SCROLL_X, 9'd3);
          write_reg(CFG_SCROLL_Y, 9'd2);
          write_reg(CFG_SCROLL_WIDTH, 9'd511);
        end
        default: begin
          write_reg(CFG_SCROLL_X, 9'($urandom_range(0, 3)));
          write_reg(CFG_SCROLL_Y, 9'($urandom_range(0, 3)));
          write_reg(CFG_SCROLL_WIDTH, 9'($urandom_range(0, 511)));
        end
      endcase
      n = 0;
      while (n < RANDOM_ITEMS) begin
        r = $urandom_range(0, 99);
        if (r < 33) begin
          wi = ($urandom_range(0, 99) < 8) ? 4'($urandom_range(12, 15))
                                           : 4'($urandom_range(0, 11));
          send_command(CMD_WRITE, 1'($urandom), 6'($urandom), wi, $urandom);
          if (wi < WORDS_PER_LINE) n++;
        end else begin
          send_command((r < 80) ? CMD_SCAN : (r < 92) ? CMD_SCROLL : CMD_HOME,
                       1'($urandom), 6'($urandom), 4'($urandom), $urandom);
          n++;
        end
      end
    end
  endtask

  always @(posedge clk) begin
    m_tready <= $urandom_range(0, 99) >= recv_idle_pct;
  end

  always @(posedge clk) begin
    if (!rst && m_tvalid && m_tready) begin
      if (expected_beats.size() == 0) begin
        $error("unexpected output transfer: m_tdata %0h m_tlast %0b", m_tdata, m_tlast);
        errors++;
      end else begin
        got = expected_beats.pop_front();
        beats++;
        if (m_tdata[0] !== got.row_bit) begin
          $error("row_bit: expected %0b, got %0b", got.row_bit, m_tdata[0]);
          errors++;
        end
        if (m_tdata[1] !== got.col_a_bit) begin
          $error("col_a_bit: expected %0b, got %0b", got.col_a_bit, m_tdata[1]);
          errors++;
        end
        if (m_tdata[2] !== got.col_b_bit) begin
          $error("col_b_bit: expected %0b, got %0b", got.col_b_bit, m_tdata[2]);
          errors++;
        end
        if (m_tlast !== got.last) begin
          $error("last: expected %0b, got %0b", got.last, m_tlast);
          errors++;
        end
      end
    end
  end

  always @(posedge clk) begin
    if ((s_tvalid && s_tready) || (m_tvalid && m_tready)) begin
      stall_count <= 0;
    end else if (stall_count >= STALL_LIMIT) begin
      $display("Timeout: no transfer for %0d cycles.", STALL_LIMIT);
      $display("FAIL");
      $finish;
    end else begin
      stall_count <= stall_count + 1;
    end
  end

  initial begin
    for (int pl = 0; pl < 2; pl++)
      for (int ln = 0; ln < BUFFER_LINES; ln++)
        for (int w = 0; w < WORDS_PER_LINE; w++)
          pix_mem[pl][ln][w] = '0;
    scan_row = '0;
    frame_phase = '0;
    view_left = '0;
    view_top = '0;
    step_x = 2'd1;
    step_y = 2'd0;
    wrap_width = 9'd384;
    repeat (2) @(posedge clk);
    rst <= 1'b0;
    test_buffer_extremes();
    test_scroll_and_home();
    test_width_limits();
    test_random_traffic();
    wait_for_quiet();
    $display("Sent %0d commands including %0d scan ticks, checked %0d shift beats.",
             commands, scans, beats);
    $display("Applied %0d register writes under three idle patterns; frame phase now %0d.",
             reg_writes, frame_phase);
    if (errors == 0 && expected_beats.size() == 0) begin
      $display("PASS");
    end else begin
      $display("FAIL");
    end
    $finish;
  end

endmodule
`default_nettype wire

// ----- files.f -----
rtl/slmx_pkg.sv
rtl/slmx_ram.sv
rtl/slmx_front.sv
rtl/slmx_fifo.sv
rtl/slmx_back.sv
rtl/scrolling_led_matrix_scanner_top.sv
bench/scrolling_led_matrix_scanner_top_tb.sv
